/* hw/rtl/lscm_pkg.sv */
// Shared definitions for the looping sample crossfade mixer.
// Field widths, register indexes, opcodes and default sizes; no dependencies.
`timescale 1ns / 1ps

package lscm_pkg;

    // Default sizes for the top-level parameters
    localparam int NUM_SOUNDS_DEF = 4;
    localparam int LOOP_DEPTH_DEF = 262144;

    // Word field widths
    localparam int OPCODE_W = 2;
    localparam int SOUND_ID_W = 2;
    localparam int FRAMES_W = 20;
    localparam int ADDR_W = 18;
    localparam int SAMPLE_W = 16;
    localparam int VOLUME_W = 17;
    localparam int FADE_W = 17;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = VOLUME_W;
    localparam logic [CFG_INDEX_W-1:0] REG_VOLUME = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLED = 2'd1;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_TICK = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SELECT = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOAD = 2'd2;

    // Q1.16 unity gain and completed fade position
    localparam logic [FADE_W-1:0] UNITY = 17'h10000;

endpackage

/* hw/rtl/lscm_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module lscm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/loop_sample_crossfade_mixer_unit.sv */
// Looping sample player: per-sound loops in one RAM, linear crossfade, volume.
// Depends on lscm_pkg and lscm_ram.
//
// Usage:
//   Input words arrive on item_valid / item_stall with the fields opcode,
//   sound_id, fade_frames, word_address, sample_value and is_last. A word is
//   taken on a clock edge with item_valid high and item_stall low.
//   Result words leave on result_valid / result_stall carrying sample_out.
//   Only a tick produces a result word; select and load produce none.
//   Configuration (volume, enabled) goes through cfg_wr_en / cfg_index /
//   cfg_wdata, one register per edge; the user writes it only while the
//   block is idle, which the block itself does not enforce.
// Sequence:
//   Load: one RAM write. Select: a bit-serial divider, DW = 20 bits wide at
//   the default sizes, forms 65536 / frames.
//   Enabled tick: one read per sound on the single RAM read port (registered
//   read), two multiply stages and the output stage; the output stage holds
//   while a stalled result word is pending. A phase beyond the loop length
//   first takes the remainder in the same divider. Disabled tick: straight
//   to the output stage with a zero result.
// Reset clears all loop lengths (every loop empty), fade state and control
// registers; loop RAM contents stay undefined until loaded. A stalled result
// word holds in the output register; the next word can still be taken, and a
// new tick waits in its final stage until the register frees up.
`timescale 1ns / 1ps

module loop_sample_crossfade_mixer_unit
    import lscm_pkg::*;
#(
    parameter int NUM_SOUNDS = NUM_SOUNDS_DEF,
    parameter int LOOP_DEPTH = LOOP_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // input word channel
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic [OPCODE_W-1:0]        opcode,
    input  logic [SOUND_ID_W-1:0]      sound_id,
    input  logic [FRAMES_W-1:0]        fade_frames,
    input  logic [ADDR_W-1:0]          word_address,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    input  logic                       is_last,
    // result word channel
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic signed [SAMPLE_W-1:0] sample_out,
    // configuration write port
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int SIDX_W = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
    localparam int PW = $clog2(LOOP_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_SOUNDS * LOOP_DEPTH;
    localparam int AW = $clog2(MEM_DEPTH);
    localparam int DW = (PW > FRAMES_W) ? PW : FRAMES_W;
    localparam int CW = $clog2(DW);
    localparam logic [AW-1:0] LOOP_DEPTH_A = AW'(LOOP_DEPTH);
    localparam logic [CW-1:0] DIV_LAST = CW'(DW - 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PREP = 8'b0000_0010,
        S_MOD  = 8'b0000_0100,
        S_DATA = 8'b0000_1000,
        S_MIX  = 8'b0001_0000,
        S_VOL  = 8'b0010_0000,
        S_EMIT = 8'b0100_0000,
        S_DIV  = 8'b1000_0000
    } state_t;

    // control state
    state_t              state_reg, state_next;
    logic                which_reg, which_next;
    logic                result_valid_reg, result_valid_next;
    logic [VOLUME_W-1:0] volume_reg, volume_next;
    logic                enabled_reg, enabled_next;
    logic [SIDX_W-1:0]   current_reg, current_next;
    logic [SIDX_W-1:0]   target_reg, target_next;
    logic [PW-1:0]       phase_c_reg, phase_c_next;
    logic [PW-1:0]       phase_t_reg, phase_t_next;
    logic [FADE_W-1:0]   pos_reg, pos_next;
    logic [FADE_W-1:0]   step_reg, step_next;
    logic [CW-1:0]       dcnt_reg, dcnt_next;
    logic [PW-1:0]       loop_len_reg [NUM_SOUNDS];

    // datapath
    logic [SIDX_W-1:0]          sel_reg, sel_next;
    logic signed [SAMPLE_W-1:0] samp_a_reg, samp_a_next;
    logic signed [SAMPLE_W-1:0] samp_b_reg, samp_b_next;
    logic signed [31:0]         pa_reg, pa_next;
    logic signed [31:0]         pb_reg, pb_next;
    logic signed [48:0]         prod_reg, prod_next;
    logic signed [SAMPLE_W-1:0] sample_out_reg, sample_out_next;
    logic [DW-1:0]              dq_reg, dq_next;
    logic [DW-1:0]              drem_reg, drem_next;
    logic [DW-1:0]              dvs_reg, dvs_next;

    // loop length write
    logic              len_we;
    logic [SIDX_W-1:0] len_wr_idx;
    logic [PW-1:0]     len_wr_val;

    // RAM ports
    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic                mem_rd_en;
    logic [PW-1:0]       rd_idx;
    logic [AW-1:0]       mem_rd_addr;
    logic [SAMPLE_W-1:0] mem_rd_data;

    // decode and shared combinational terms
    logic              item_accept;
    logic              snd_ok;
    logic              addr_ok;
    logic [SIDX_W-1:0] snd_idx;
    logic [SIDX_W-1:0] cur_snd;
    logic [PW-1:0]     cur_phase;
    logic [PW-1:0]     cur_len;
    logic [DW:0]       trial;
    logic              trial_ge;
    logic [DW-1:0]     rem_step;
    logic [DW-1:0]     q_step;
    logic              fading;
    logic [FADE_W-1:0] w_a;
    logic [FADE_W-1:0] w_b;
    logic signed [33:0] pa_full;
    logic signed [33:0] pb_full;
    logic signed [31:0] mix_sum;
    logic signed [49:0] prod_full;
    logic [48:0]        biased;
    logic [FADE_W:0]    pos_sum;

    assign item_stall = (state_reg != S_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign sample_out = sample_out_reg;

    assign snd_ok = (32'(sound_id) < 32'(NUM_SOUNDS));
    assign addr_ok = (32'(word_address) < 32'(LOOP_DEPTH));
    assign snd_idx = SIDX_W'(sound_id);

    // sound under service: current for the first read, target for the second
    assign cur_snd = which_reg ? target_reg : current_reg;
    assign cur_phase = which_reg ? phase_t_reg : phase_c_reg;
    assign cur_len = loop_len_reg[cur_snd];
    assign mem_rd_addr = AW'(cur_snd) * LOOP_DEPTH_A + AW'(rd_idx);

    // one restoring divide step per cycle
    assign trial = {drem_reg, dq_reg[DW-1]};
    assign trial_ge = (trial >= {1'b0, dvs_reg});
    assign rem_step = trial_ge ? DW'(trial - {1'b0, dvs_reg}) : trial[DW-1:0];
    assign q_step = {dq_reg[DW-2:0], trial_ge};

    // crossfade weights; with the fade done only the target sounds
    assign fading = (pos_reg < UNITY);
    assign w_a = fading ? FADE_W'(UNITY - pos_reg) : '0;
    assign w_b = fading ? pos_reg : UNITY;
    assign pa_full = samp_a_reg * $signed({1'b0, w_a});
    assign pb_full = samp_b_reg * $signed({1'b0, w_b});
    assign pos_sum = {1'b0, pos_reg} + {1'b0, step_reg};

    assign mix_sum = pa_reg + pb_reg;
    assign prod_full = mix_sum * $signed({1'b0, volume_reg});

    // truncate toward zero: bias negative values before the arithmetic shift
    assign biased = prod_reg + (prod_reg[48] ? 49'h0_FFFF_FFFF : 49'h0);

    always_comb
    begin
        state_next = state_reg;
        which_next = which_reg;
        result_valid_next = result_valid_reg;
        volume_next = volume_reg;
        enabled_next = enabled_reg;
        current_next = current_reg;
        target_next = target_reg;
        phase_c_next = phase_c_reg;
        phase_t_next = phase_t_reg;
        pos_next = pos_reg;
        step_next = step_reg;
        dcnt_next = dcnt_reg;
        sel_next = sel_reg;
        samp_a_next = samp_a_reg;
        samp_b_next = samp_b_reg;
        pa_next = pa_reg;
        pb_next = pb_reg;
        prod_next = prod_reg;
        sample_out_next = sample_out_reg;
        dq_next = dq_reg;
        drem_next = drem_reg;
        dvs_next = dvs_reg;
        len_we = 1'b0;
        len_wr_idx = snd_idx;
        len_wr_val = PW'(word_address) + PW'(1);
        mem_wr_en = 1'b0;
        mem_wr_addr = AW'(snd_idx) * LOOP_DEPTH_A + AW'(word_address);
        mem_rd_en = 1'b0;
        rd_idx = cur_phase;

        // configuration writes
        if (cfg_wr_en)
        begin
            if (cfg_index == REG_VOLUME)
            begin
                volume_next = (cfg_wdata > UNITY) ? UNITY : cfg_wdata;
            end
            else if (cfg_index == REG_ENABLED)
            begin
                enabled_next = cfg_wdata[0];
            end
        end

        // drop the result word once taken
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    unique case (opcode)
                        OP_TICK:
                        begin
                            if (enabled_reg)
                            begin
                                which_next = 1'b0;
                                state_next = S_PREP;
                            end
                            else
                            begin
                                prod_next = '0;
                                state_next = S_EMIT;
                            end
                        end
                        OP_SELECT:
                        begin
                            if (snd_ok && (snd_idx != target_reg))
                            begin
                                sel_next = snd_idx;
                                dq_next = DW'(UNITY);
                                drem_next = '0;
                                dvs_next = (fade_frames == '0) ? DW'(1) : DW'(fade_frames);
                                dcnt_next = '0;
                                state_next = S_DIV;
                            end
                        end
                        OP_LOAD:
                        begin
                            if (snd_ok && addr_ok)
                            begin
                                mem_wr_en = 1'b1;
                                len_we = is_last;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_PREP:
            begin
                if (cur_len == '0)
                begin
                    // empty loop: silence, phase holds
                    if (which_reg)
                    begin
                        samp_b_next = '0;
                        state_next = S_MIX;
                    end
                    else
                    begin
                        samp_a_next = '0;
                        which_next = 1'b1;
                        state_next = S_PREP;
                    end
                end
                else if (cur_phase < cur_len || cur_phase == cur_len)
                begin
                    rd_idx = (cur_phase == cur_len) ? '0 : cur_phase;
                    mem_rd_en = 1'b1;
                    if (which_reg)
                    begin
                        phase_t_next = rd_idx + PW'(1);
                    end
                    else
                    begin
                        phase_c_next = rd_idx + PW'(1);
                    end
                    state_next = S_DATA;
                end
                else
                begin
                    // phase past the end of a shortened loop: take the remainder
                    dq_next = DW'(cur_phase);
                    drem_next = '0;
                    dvs_next = DW'(cur_len);
                    dcnt_next = '0;
                    state_next = S_MOD;
                end
            end

            S_MOD:
            begin
                dq_next = q_step;
                drem_next = rem_step;
                dcnt_next = dcnt_reg + CW'(1);
                if (dcnt_reg == DIV_LAST)
                begin
                    rd_idx = PW'(rem_step);
                    mem_rd_en = 1'b1;
                    if (which_reg)
                    begin
                        phase_t_next = rd_idx + PW'(1);
                    end
                    else
                    begin
                        phase_c_next = rd_idx + PW'(1);
                    end
                    state_next = S_DATA;
                end
            end

            S_DATA:
            begin
                if (which_reg)
                begin
                    samp_b_next = $signed(mem_rd_data);
                    state_next = S_MIX;
                end
                else
                begin
                    samp_a_next = $signed(mem_rd_data);
                    which_next = 1'b1;
                    state_next = S_PREP;
                end
            end

            S_MIX:
            begin
                pa_next = pa_full[31:0];
                pb_next = pb_full[31:0];
                // advance the fade; on completion hand over to the target
                if (fading)
                begin
                    if (pos_sum >= {1'b0, UNITY})
                    begin
                        pos_next = UNITY;
                        current_next = target_reg;
                        phase_c_next = phase_t_reg;
                    end
                    else
                    begin
                        pos_next = pos_sum[FADE_W-1:0];
                    end
                end
                else
                begin
                    current_next = target_reg;
                end
                state_next = S_VOL;
            end

            S_VOL:
            begin
                prod_next = prod_full[48:0];
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    sample_out_next = biased[47:32];
                    state_next = S_IDLE;
                end
            end

            S_DIV:
            begin
                dq_next = q_step;
                drem_next = rem_step;
                dcnt_next = dcnt_reg + CW'(1);
                if (dcnt_reg == DIV_LAST)
                begin
                    step_next = (q_step == '0) ? FADE_W'(1) : q_step[FADE_W-1:0];
                    current_next = target_reg;
                    target_next = sel_reg;
                    phase_t_next = '0;
                    pos_next = '0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            which_reg <= 1'b0;
            result_valid_reg <= 1'b0;
            volume_reg <= UNITY;
            enabled_reg <= 1'b0;
            current_reg <= '0;
            target_reg <= '0;
            phase_c_reg <= '0;
            phase_t_reg <= '0;
            pos_reg <= UNITY;
            step_reg <= UNITY;
            dcnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            which_reg <= which_next;
            result_valid_reg <= result_valid_next;
            volume_reg <= volume_next;
            enabled_reg <= enabled_next;
            current_reg <= current_next;
            target_reg <= target_next;
            phase_c_reg <= phase_c_next;
            phase_t_reg <= phase_t_next;
            pos_reg <= pos_next;
            step_reg <= step_next;
            dcnt_reg <= dcnt_next;
        end
    end

    // loop lengths: all loops empty after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SOUNDS; i++)
            begin
                loop_len_reg[i] <= '0;
            end
        end
        else if (len_we)
        begin
            loop_len_reg[len_wr_idx] <= len_wr_val;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
        samp_a_reg <= samp_a_next;
        samp_b_reg <= samp_b_next;
        pa_reg <= pa_next;
        pb_reg <= pb_next;
        prod_reg <= prod_next;
        sample_out_reg <= sample_out_next;
        dq_reg <= dq_next;
        drem_reg <= drem_next;
        dvs_reg <= dvs_next;
    end

    // loop sample store, all sounds back to back
    lscm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MEM_DEPTH)
    ) u_loop_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (sample_value),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule
